// File: src/tfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

  // Field widths of the command and status words.
  localparam int MODE_W   = 3;
  localparam int PINS_W   = 2;
  localparam int MHZ_W    = 10;
  localparam int TENTH_W  = 4;
  localparam int FREQ_W   = 14;
  localparam int OFFSET_W = 12;
  localparam int DIVH_W   = 7;
  localparam int BYTE_W   = 8;
  localparam int SBAND_W  = 4;
  localparam int SLOTS    = 2;
  localparam int SLOT_W   = 1;

  // Configuration port geometry.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_SEL_W  = 3;

  // Register reset values.
  localparam logic [FREQ_W-1:0]   MIN_TENTHS_RST     = 14'd450;
  localparam logic [FREQ_W-1:0]   MAX_TENTHS_RST     = 14'd8700;
  localparam logic [OFFSET_W-1:0] IF_OFFSET_RST      = 12'd754;
  localparam logic [FREQ_W-1:0]   VHF_HIGH_START_RST = 14'd1520;
  localparam logic [FREQ_W-1:0]   UHF_START_RST      = 14'd4370;
  localparam logic [FREQ_W-1:0]   FREQ_RST           = 14'd450;

  // Direct entry limits in whole MHz and the largest tenth digit.
  localparam logic [MHZ_W-1:0]   ENTRY_MHZ_MIN = 10'd45;
  localparam logic [MHZ_W-1:0]   ENTRY_MHZ_MAX = 10'd870;
  localparam logic [TENTH_W-1:0] TENTH_MAX     = 4'd9;

  // Tuner control and band bytes.
  localparam logic [BYTE_W-1:0] CTRL_BASE     = 8'b1100_0000;
  localparam logic [BYTE_W-1:0] CTRL_STANDBY  = 8'b1100_1000;
  localparam logic [BYTE_W-1:0] BAND_VHF_LOW  = 8'b0000_0001;
  localparam logic [BYTE_W-1:0] BAND_VHF_HIGH = 8'b0000_0010;
  localparam logic [BYTE_W-1:0] BAND_UHF      = 8'b0000_1000;
  localparam logic [BYTE_W-1:0] BAND_STANDBY  = 8'b0000_0011;

  // Command kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_ENCODER = 3'd0,
    MODE_ENTRY   = 3'd1,
    MODE_BOOSTER = 3'd2,
    MODE_STANDBY = 3'd3,
    MODE_SLOT    = 3'd4
  } mode_t;

  // Register indexes on the configuration port.
  typedef enum logic [REG_SEL_W-1:0] {
    REG_MIN_TENTHS     = 3'd0,
    REG_MAX_TENTHS     = 3'd1,
    REG_IF_OFFSET      = 3'd2,
    REG_VHF_HIGH_START = 3'd3,
    REG_UHF_START      = 3'd4
  } reg_sel_t;

  // Service band codes.
  typedef enum logic [SBAND_W-1:0] {
    SB_NONE  = 4'd0,
    SB_FM    = 4'd1,
    SB_AIR   = 4'd2,
    SB_SAT   = 4'd3,
    SB_DAB   = 4'd4,
    SB_MIL   = 4'd5,
    SB_ISM   = 4'd6,
    SB_2M    = 4'd7,
    SB_IZS   = 4'd8,
    SB_70CM  = 4'd9,
    SB_WBL   = 4'd10,
    SB_TETRA = 4'd11,
    SB_PMR   = 4'd12,
    SB_6M    = 4'd13,
    SB_HLS   = 4'd14,
    SB_4M    = 4'd15
  } sband_t;

endpackage

`default_nettype wire

// File: src/tfc_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one word per encoder sample, key entry or button event.
interface tfc_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [tfc_pkg::MODE_W-1:0]    mode;
  logic [tfc_pkg::PINS_W-1:0]    encoder_pins;
  logic [tfc_pkg::MHZ_W-1:0]     entry_mhz;
  logic [tfc_pkg::TENTH_W-1:0]   entry_tenth;
  logic [tfc_pkg::SLOT_W-1:0]    slot_index;

  modport source (
    output valid, mode, encoder_pins, entry_mhz, entry_tenth, slot_index,
    input  ready
  );

  modport sink (
    input  valid, mode, encoder_pins, entry_mhz, entry_tenth, slot_index,
    output ready
  );
endinterface

`default_nettype wire

// File: src/tfc_status_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Status channel: the tuner word and flags produced for each command word.
interface tfc_status_if;
  logic                          valid;
  logic                          ready;
  logic [tfc_pkg::DIVH_W-1:0]    divider_high;
  logic [tfc_pkg::BYTE_W-1:0]    divider_low;
  logic [tfc_pkg::BYTE_W-1:0]    control_byte;
  logic [tfc_pkg::BYTE_W-1:0]    band_byte;
  logic [tfc_pkg::FREQ_W-1:0]    frequency_tenths;
  logic [tfc_pkg::SBAND_W-1:0]   service_band;
  logic                          limit_hit;
  logic                          entry_error;
  logic                          booster_on;
  logic [tfc_pkg::SLOTS-1:0]     slot_full;

  modport source (
    output valid, divider_high, divider_low, control_byte, band_byte,
           frequency_tenths, service_band, limit_hit, entry_error,
           booster_on, slot_full,
    input  ready
  );

  modport sink (
    input  valid, divider_high, divider_low, control_byte, band_byte,
           frequency_tenths, service_band, limit_hit, entry_error,
           booster_on, slot_full,
    output ready
  );
endinterface

`default_nettype wire

// File: src/tuner_frequency_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Modport  Handshake            Carries
// cmd        sink     valid/ready          one command word (encoder, entry, button)
// status     source   valid/ready          one tuner word and flags per command word
// APB        slave    psel/penable/pwrite  five tuning limit and band registers
//
// A command word is registered on acceptance and turned into its status word when the
// status register advances; one word is taken every cycle while status words are taken.
// The status register and the command register form a two-entry pipeline; when the
// status word is not taken, the command register still fills once before ready drops.
// Synchronous reset restores the registers and the tuning state; memory slots read
// empty after reset and their stored frequencies are only read once written.

module tuner_frequency_controller (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tfc_cmd_if.sink                              cmd,
  tfc_status_if.source                         status,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tfc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [tfc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [tfc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  localparam int FREQ_W   = tfc_pkg::FREQ_W;
  localparam int SIGNED_W = FREQ_W + 2;
  localparam int DIV_W    = FREQ_W + 2;

  // Configuration registers.
  logic [FREQ_W-1:0]            min_tenths;
  logic [FREQ_W-1:0]            max_tenths;
  logic [tfc_pkg::OFFSET_W-1:0] if_offset;
  logic [FREQ_W-1:0]            vhf_high_start;
  logic [FREQ_W-1:0]            uhf_start;

  // Tuning state.
  logic [FREQ_W-1:0]            freq;
  logic [tfc_pkg::PINS_W-1:0]   last_pins;
  logic                         booster;
  logic [tfc_pkg::SLOTS-1:0]    slot_valid;
  logic [FREQ_W-1:0]            slot_freq [tfc_pkg::SLOTS];

  // Command register.
  logic                         cmd_valid;
  logic [tfc_pkg::MODE_W-1:0]   cmd_mode;
  logic [tfc_pkg::PINS_W-1:0]   cmd_pins;
  logic [tfc_pkg::MHZ_W-1:0]    cmd_mhz;
  logic [tfc_pkg::TENTH_W-1:0]  cmd_tenth;
  logic [tfc_pkg::SLOT_W-1:0]   cmd_slot;

  // Status register valid.
  logic                         out_valid;

  logic advance;
  logic load;
  logic cfg_write;
  logic [tfc_pkg::REG_SEL_W-1:0] reg_sel;

  // Encoder step: +1 on a forward quadrature transition, -1 on a reverse one.
  function automatic logic signed [SIGNED_W-1:0] encoder_step(
    input logic [tfc_pkg::PINS_W-1:0] prev,
    input logic [tfc_pkg::PINS_W-1:0] cur
  );
    logic [tfc_pkg::PINS_W-1:0] up;
    logic [tfc_pkg::PINS_W-1:0] down;
    case (prev)
      2'b00:   begin up = 2'b01; down = 2'b10; end
      2'b01:   begin up = 2'b11; down = 2'b00; end
      2'b10:   begin up = 2'b00; down = 2'b11; end
      default: begin up = 2'b10; down = 2'b01; end
    endcase
    if (cur == up) begin
      return SIGNED_W'(1);
    end else if (cur == down) begin
      return -SIGNED_W'(1);
    end else begin
      return '0;
    end
  endfunction

  // Service band lookup; the first matching range wins.
  function automatic tfc_pkg::sband_t band_of(input logic [FREQ_W-1:0] f);
    if (f inside {[14'd876:14'd1080]}) return tfc_pkg::SB_FM;
    if (f inside {[14'd1081:14'd1360]}) return tfc_pkg::SB_AIR;
    if (f inside {[14'd1370:14'd1380]}) return tfc_pkg::SB_SAT;
    if (f inside {[14'd1740:14'd2390]}) return tfc_pkg::SB_DAB;
    if (f inside {[14'd2391:14'd3799]}) return tfc_pkg::SB_MIL;
    if (f inside {[14'd4330:14'd4348], [14'd8550:14'd8680]}) return tfc_pkg::SB_ISM;
    if (f inside {[14'd1440:14'd1480]}) return tfc_pkg::SB_2M;
    if (f inside {[14'd1600:14'd1740]}) return tfc_pkg::SB_IZS;
    if (f inside {[14'd4300:14'd4400]}) return tfc_pkg::SB_70CM;
    if (f inside {[14'd4000:14'd4060]}) return tfc_pkg::SB_WBL;
    if (f inside {[14'd4100:14'd4299], [14'd3800:14'd3999]}) return tfc_pkg::SB_TETRA;
    if (f inside {[14'd4460:14'd4462]}) return tfc_pkg::SB_PMR;
    if (f inside {[14'd500:14'd540]}) return tfc_pkg::SB_6M;
    if (f inside {[14'd676:14'd713]}) return tfc_pkg::SB_HLS;
    if (f inside {[14'd714:14'd728]}) return tfc_pkg::SB_4M;
    return tfc_pkg::SB_NONE;
  endfunction

  // Configuration port: writes complete in the access phase, reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = paddr[tfc_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_tenths     <= tfc_pkg::MIN_TENTHS_RST;
      max_tenths     <= tfc_pkg::MAX_TENTHS_RST;
      if_offset      <= tfc_pkg::IF_OFFSET_RST;
      vhf_high_start <= tfc_pkg::VHF_HIGH_START_RST;
      uhf_start      <= tfc_pkg::UHF_START_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        tfc_pkg::REG_MIN_TENTHS:     min_tenths     <= pwdata[FREQ_W-1:0];
        tfc_pkg::REG_MAX_TENTHS:     max_tenths     <= pwdata[FREQ_W-1:0];
        tfc_pkg::REG_IF_OFFSET:      if_offset      <= pwdata[tfc_pkg::OFFSET_W-1:0];
        tfc_pkg::REG_VHF_HIGH_START: vhf_high_start <= pwdata[FREQ_W-1:0];
        tfc_pkg::REG_UHF_START:      uhf_start      <= pwdata[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tfc_pkg::REG_MIN_TENTHS:     prdata = tfc_pkg::APB_DATA_W'(min_tenths);
      tfc_pkg::REG_MAX_TENTHS:     prdata = tfc_pkg::APB_DATA_W'(max_tenths);
      tfc_pkg::REG_IF_OFFSET:      prdata = tfc_pkg::APB_DATA_W'(if_offset);
      tfc_pkg::REG_VHF_HIGH_START: prdata = tfc_pkg::APB_DATA_W'(vhf_high_start);
      tfc_pkg::REG_UHF_START:      prdata = tfc_pkg::APB_DATA_W'(uhf_start);
      default:                     prdata = '0;
    endcase
  end

  // Pipeline control: the status register moves when empty or taken.
  assign advance   = !out_valid || status.ready;
  assign load      = cmd_valid && advance;
  assign cmd.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        cmd_valid <= 1'b1;
      end else if (load) begin
        cmd_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_mode  <= cmd.mode;
      cmd_pins  <= cmd.encoder_pins;
      cmd_mhz   <= cmd.entry_mhz;
      cmd_tenth <= cmd.entry_tenth;
      cmd_slot  <= cmd.slot_index;
    end
  end

  // Command decode and new frequency before the clamp.
  logic signed [SIGNED_W-1:0]    freq_cand;
  logic [tfc_pkg::PINS_W-1:0]    last_pins_next;
  logic                          booster_next;
  logic [tfc_pkg::SLOTS-1:0]     slot_valid_next;
  logic                          slot_store;
  logic                          standby;
  logic                          entry_error;
  logic [tfc_pkg::TENTH_W-1:0]   tenth_sat;
  logic [FREQ_W-1:0]             entry_freq;

  always_comb begin
    tenth_sat  = (cmd_tenth > tfc_pkg::TENTH_MAX) ? tfc_pkg::TENTH_MAX : cmd_tenth;
    entry_freq = (FREQ_W'(cmd_mhz) << 3) + (FREQ_W'(cmd_mhz) << 1) + FREQ_W'(tenth_sat);

    freq_cand       = SIGNED_W'(freq);
    last_pins_next  = last_pins;
    booster_next    = booster;
    slot_valid_next = slot_valid;
    slot_store      = 1'b0;
    standby         = 1'b0;
    entry_error     = 1'b0;

    case (cmd_mode)
      tfc_pkg::MODE_ENCODER: begin
        freq_cand      = SIGNED_W'(freq) + encoder_step(last_pins, cmd_pins);
        last_pins_next = cmd_pins;
      end
      tfc_pkg::MODE_ENTRY: begin
        if (cmd_mhz < tfc_pkg::ENTRY_MHZ_MIN || cmd_mhz > tfc_pkg::ENTRY_MHZ_MAX) begin
          entry_error = 1'b1;
        end else begin
          freq_cand = SIGNED_W'(entry_freq);
        end
      end
      tfc_pkg::MODE_BOOSTER: begin
        booster_next = !booster;
      end
      tfc_pkg::MODE_STANDBY: begin
        standby = 1'b1;
      end
      tfc_pkg::MODE_SLOT: begin
        // An empty slot stores the frequency, a full one is recalled and emptied.
        if (!slot_valid[cmd_slot]) begin
          slot_store = 1'b1;
        end else begin
          freq_cand = SIGNED_W'(slot_freq[cmd_slot]);
        end
        slot_valid_next[cmd_slot] = !slot_valid[cmd_slot];
      end
      default: ;
    endcase
  end

  // Clamp to the limits; the lower limit has the last word.
  // The compares are signed so that a step below zero reaches the lower limit.
  logic signed [SIGNED_W-1:0] freq_upper;
  logic signed [SIGNED_W-1:0] freq_clamped;
  logic                       hit_upper;
  logic                       hit_lower;
  logic [FREQ_W-1:0]          freq_next;

  always_comb begin
    hit_upper    = freq_cand > $signed(SIGNED_W'(max_tenths));
    freq_upper   = hit_upper ? $signed(SIGNED_W'(max_tenths)) : freq_cand;
    hit_lower    = freq_upper < $signed(SIGNED_W'(min_tenths));
    freq_clamped = hit_lower ? $signed(SIGNED_W'(min_tenths)) : freq_upper;
    freq_next    = freq_clamped[FREQ_W-1:0];
  end

  // Tuner word from the new frequency.
  logic [DIV_W-1:0]            divider;
  logic [tfc_pkg::BYTE_W-1:0]  control_next;
  logic [tfc_pkg::BYTE_W-1:0]  band_next;

  always_comb begin
    divider = {1'b0, freq_next, 1'b0} + DIV_W'(if_offset);
    if (standby) begin
      control_next = tfc_pkg::CTRL_STANDBY;
      band_next    = tfc_pkg::BAND_STANDBY;
    end else begin
      control_next = tfc_pkg::CTRL_BASE | tfc_pkg::BYTE_W'(booster_next);
      if (freq_next < vhf_high_start) begin
        band_next = tfc_pkg::BAND_VHF_LOW;
      end else if (freq_next < uhf_start) begin
        band_next = tfc_pkg::BAND_VHF_HIGH;
      end else begin
        band_next = tfc_pkg::BAND_UHF;
      end
    end
  end

  // State update when a command word moves into the status register.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq       <= tfc_pkg::FREQ_RST;
      last_pins  <= '0;
      booster    <= 1'b0;
      slot_valid <= '0;
    end else if (load) begin
      freq       <= freq_next;
      last_pins  <= last_pins_next;
      booster    <= booster_next;
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && slot_store) begin
      slot_freq[cmd_slot] <= freq;
    end
  end

  // Status register.
  always_ff @(posedge clk) begin
    if (load) begin
      status.divider_high     <= standby ? '0 : divider[tfc_pkg::DIVH_W+7:8];
      status.divider_low      <= standby ? '0 : divider[7:0];
      status.control_byte     <= control_next;
      status.band_byte        <= band_next;
      status.frequency_tenths <= freq_next;
      status.service_band     <= band_of(freq_next);
      status.limit_hit        <= hit_upper || hit_lower;
      status.entry_error      <= entry_error;
      status.booster_on       <= booster_next;
      status.slot_full        <= slot_valid_next;
    end
  end

  assign status.valid = out_valid;

  // A freshly produced word never lies below the lower limit in force when it was made.
  a_freq_above_min: assert property (@(posedge clk) disable iff (rst)
    load |=> status.frequency_tenths >= $past(min_tenths))
    else $error("frequency below lower limit");

  // The standby control byte and the standby band byte always come together.
  a_standby_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status.control_byte == tfc_pkg::CTRL_STANDBY) ==
                   (status.band_byte == tfc_pkg::BAND_STANDBY)))
    else $error("standby bytes disagree");

  // Slot flags change only when a command word is processed.
  a_slots_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(slot_valid))
    else $error("slot flags changed without a command word");

  // The command side stalls only behind a full pipeline whose status word waits.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (cmd_valid && out_valid && !status.ready))
    else $error("command ready dropped without a stall");

endmodule

`default_nettype wire

// File: dv/tb_tuner_frequency_controller.sv
`timescale 1ns / 1ps

module tb_tuner_frequency_controller;
  import tfc_pkg::*;

  // Command codes the block must treat as no-ops.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_ROWS       = 25;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PINS_W-1:0]  pins;
    logic [MHZ_W-1:0]   mhz;
    logic [TENTH_W-1:0] tenth;
    logic [SLOT_W-1:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [DIVH_W-1:0]  div_high;
    logic [BYTE_W-1:0]  div_low;
    logic [BYTE_W-1:0]  ctrl;
    logic [BYTE_W-1:0]  band;
    logic [FREQ_W-1:0]  freq;
    logic [SBAND_W-1:0] sband;
    logic               hit;
    logic               err;
    logic               boost;
    logic [SLOTS-1:0]   slots;
  } status_t;

  // One row of the directed table; pinned rows carry a hand-written frequency and flags.
  typedef struct packed {
    cmd_t              cmd;
    logic              pinned;
    logic [FREQ_W-1:0] freq;
    logic              err;
    logic              hit;
  } row_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   lo;
    logic [FREQ_W-1:0]   hi;
    logic [OFFSET_W-1:0] offset;
    logic [FREQ_W-1:0]   vhf_high;
    logic [FREQ_W-1:0]   uhf;
  } tuning_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tfc_cmd_if    cmd_if ();
  tfc_status_if stat_if ();

  tuner_frequency_controller u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .status  (stat_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Predicted tuner state and register copy.
  tuning_cfg_t       cfg;
  logic [FREQ_W-1:0] freq_st;
  logic [PINS_W-1:0] pins_st;
  logic              boost_st;
  logic              slot_ok [SLOTS];
  logic [FREQ_W-1:0] slot_tenths [SLOTS];

  status_t words_due [$];
  int      mismatches    = 0;
  int      words_checked = 0;
  int      idle_cycles   = 0;

  // Sender state: burst length and the encoder walk.
  int                burst_left = 0;
  int                enc_left   = 0;
  bit                enc_up;
  bit                enc_noise;
  logic [PINS_W-1:0] drv_pins   = '0;

  // Hand-written expectation travelling with the word being driven.
  logic              cur_pinned   = 1'b0;
  logic [FREQ_W-1:0] cur_pin_freq = '0;
  logic              cur_pin_err  = 1'b0;
  logic              cur_pin_hit  = 1'b0;

  // Receiver stall pattern.
  int rcv_kind = 0;
  int rcv_left = 0;

  row_t dir_rows [0:N_ROWS-1];

  // One quadrature step: +1 along 00-01-11-10, -1 the other way, else nothing.
  function automatic int quad_step(logic [PINS_W-1:0] prev, logic [PINS_W-1:0] cur);
    case ({prev, cur})
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: return 1;
      4'b01_00, 4'b11_01, 4'b10_11, 4'b00_10: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [PINS_W-1:0] quad_next(logic [PINS_W-1:0] p, bit up);
    case (p)
      2'b00:   return up ? 2'b01 : 2'b10;
      2'b01:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b10 : 2'b01;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  // Service band lookup; the checks are ordered, so overlaps go to the earlier band.
  function automatic sband_t band_of(logic [FREQ_W-1:0] f);
    int unsigned v;
    v = f;
    if (v >= 876 && v <= 1080) return SB_FM;
    if (v > 1080 && v <= 1360) return SB_AIR;
    if (v >= 1370 && v <= 1380) return SB_SAT;
    if (v >= 1740 && v <= 2390) return SB_DAB;
    if (v > 2390 && v < 3800) return SB_MIL;
    if ((v >= 4330 && v < 4349) || (v >= 8550 && v <= 8680)) return SB_ISM;
    if (v >= 1440 && v <= 1480) return SB_2M;
    if (v >= 1600 && v <= 1740) return SB_IZS;
    if (v >= 4300 && v <= 4400) return SB_70CM;
    if (v >= 4000 && v <= 4060) return SB_WBL;
    if ((v >= 4100 && v < 4300) || (v >= 3800 && v < 4000)) return SB_TETRA;
    if (v >= 4460 && v <= 4462) return SB_PMR;
    if (v >= 500 && v <= 540) return SB_6M;
    if (v >= 676 && v <= 713) return SB_HLS;
    if (v > 713 && v <= 728) return SB_4M;
    return SB_NONE;
  endfunction

  // Advance the predicted tuner by one command word and build its status word.
  function automatic status_t tune_step(cmd_t c);
    status_t            s;
    int                 f;
    logic [TENTH_W-1:0] tn;
    logic [16:0]        div;
    bit                 standby;
    s       = '0;
    standby = 1'b0;
    f       = int'(freq_st);
    tn      = (c.tenth > TENTH_MAX) ? TENTH_MAX : c.tenth;
    case (c.mode)
      MODE_ENCODER: begin
        f = f + quad_step(pins_st, c.pins);
        pins_st = c.pins;
      end
      MODE_ENTRY: begin
        if (c.mhz < ENTRY_MHZ_MIN || c.mhz > ENTRY_MHZ_MAX) begin
          s.err = 1'b1;
        end else begin
          f = int'(c.mhz) * 10 + int'(tn);
        end
      end
      MODE_BOOSTER: boost_st = ~boost_st;
      MODE_STANDBY: standby = 1'b1;
      MODE_SLOT: begin
        if (!slot_ok[c.slot]) begin
          slot_tenths[c.slot] = freq_st;
          slot_ok[c.slot] = 1'b1;
        end else begin
          f = int'(slot_tenths[c.slot]);
          slot_ok[c.slot] = 1'b0;
        end
      end
      default: ;
    endcase

    // The lower limit is applied last, so it wins when the limits cross.
    if (f > int'(cfg.hi)) begin
      f = int'(cfg.hi);
      s.hit = 1'b1;
    end
    if (f < int'(cfg.lo)) begin
      f = int'(cfg.lo);
      s.hit = 1'b1;
    end
    freq_st = f[FREQ_W-1:0];

    div = freq_st * 17'd2 + cfg.offset;
    if (standby) begin
      div    = '0;
      s.ctrl = CTRL_STANDBY;
      s.band = BAND_STANDBY;
    end else begin
      s.ctrl = CTRL_BASE | {7'd0, boost_st};
      if (freq_st < cfg.vhf_high) begin
        s.band = BAND_VHF_LOW;
      end else if (freq_st < cfg.uhf) begin
        s.band = BAND_VHF_HIGH;
      end else begin
        s.band = BAND_UHF;
      end
    end
    s.div_high = div[14:8];
    s.div_low  = div[7:0];
    s.freq     = freq_st;
    s.sband    = band_of(freq_st);
    s.boost    = boost_st;
    s.slots    = {slot_ok[1], slot_ok[0]};
    return s;
  endfunction

  function automatic void check_field(string nm, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("status word %0d: %s expected %0d, got %0d", words_checked, nm, want, got);
      end
    end
  endfunction

  // Receiver: stall segments of random kind and length.
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_kind = $urandom_range(0, 4);
      rcv_left = $urandom_range(1, 40);
    end
    rcv_left--;
    case (rcv_kind)
      0:       stat_if.ready = 1'b1;
      1:       stat_if.ready = $urandom_range(0, 1);
      2:       stat_if.ready = ($urandom_range(0, 3) == 0);
      3:       stat_if.ready = ~stat_if.ready;
      default: stat_if.ready = 1'b0;
    endcase
  end

  // Predict on every accepted command word, check every accepted status word.
  always @(posedge clk) begin : monitor
    status_t want;
    status_t got;
    cmd_t    c;
    bit      progress;
    if (!rst) begin
      progress = 1'b0;
      if (cmd_if.valid && cmd_if.ready) begin
        c = '{cmd_if.mode, cmd_if.encoder_pins, cmd_if.entry_mhz, cmd_if.entry_tenth,
              cmd_if.slot_index};
        want = tune_step(c);
        if (cur_pinned) begin
          want.freq = cur_pin_freq;
          want.err  = cur_pin_err;
          want.hit  = cur_pin_hit;
        end
        words_due.push_back(want);
        progress = 1'b1;
      end
      if (stat_if.valid && stat_if.ready) begin
        progress = 1'b1;
        got = '{stat_if.divider_high, stat_if.divider_low, stat_if.control_byte,
                stat_if.band_byte, stat_if.frequency_tenths, stat_if.service_band,
                stat_if.limit_hit, stat_if.entry_error, stat_if.booster_on,
                stat_if.slot_full};
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("status word with nothing pending: freq %0d", got.freq);
          end
        end else begin
          want = words_due.pop_front();
          check_field("divider_high", want.div_high, got.div_high);
          check_field("divider_low", want.div_low, got.div_low);
          check_field("control_byte", want.ctrl, got.ctrl);
          check_field("band_byte", want.band, got.band);
          check_field("frequency_tenths", want.freq, got.freq);
          check_field("service_band", want.sband, got.sband);
          check_field("limit_hit", want.hit, got.hit);
          check_field("entry_error", want.err, got.err);
          check_field("booster_on", want.boost, got.boost);
          check_field("slot_full", want.slots, got.slots);
          words_checked++;
        end
      end
      // Watchdog on a stuck handshake.
      if (progress) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Drive one command word; entered and left at a falling edge.
  task automatic send(cmd_t c, logic pinned, logic [FREQ_W-1:0] pf, logic pe, logic ph);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd_if.mode         = c.mode;
    cmd_if.encoder_pins = c.pins;
    cmd_if.entry_mhz    = c.mhz;
    cmd_if.entry_tenth  = c.tenth;
    cmd_if.slot_index   = c.slot;
    cur_pinned          = pinned;
    cur_pin_freq        = pf;
    cur_pin_err         = pe;
    cur_pin_hit         = ph;
    cmd_if.valid        = 1'b1;
    if (c.mode == MODE_ENCODER) begin
      drv_pins = c.pins;
    end
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random command word: mostly clean encoder runs, with entries, buttons and noise.
  task automatic make_cmd(output cmd_t c);
    int sel;
    sel     = $urandom_range(0, 99);
    c.pins  = $urandom_range(0, 3);
    c.mhz   = $urandom_range(0, 1023);
    c.tenth = $urandom_range(0, 15);
    c.slot  = $urandom_range(0, 1);
    if (sel < 55) begin
      c.mode = MODE_ENCODER;
      if (enc_left == 0) begin
        enc_noise = ($urandom_range(0, 9) == 0);
        enc_up    = $urandom_range(0, 1);
        enc_left  = $urandom_range(1, 40);
      end
      enc_left--;
      if (!enc_noise) begin
        c.pins = quad_next(drv_pins, enc_up);
      end
    end else if (sel < 70) begin
      c.mode = MODE_ENTRY;
      if ($urandom_range(0, 9) < 8) begin
        c.mhz = $urandom_range(45, 870);
      end
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       c.mhz = ENTRY_MHZ_MIN - 1;
          1:       c.mhz = ENTRY_MHZ_MIN;
          2:       c.mhz = ENTRY_MHZ_MAX;
          default: c.mhz = ENTRY_MHZ_MAX + 1;
        endcase
      end
      if ($urandom_range(0, 9) < 8) begin
        c.tenth = $urandom_range(0, 9);
      end
    end else if (sel < 76) begin
      c.mode = MODE_BOOSTER;
    end else if (sel < 82) begin
      c.mode = MODE_STANDBY;
    end else if (sel < 96) begin
      c.mode = MODE_SLOT;
    end else begin
      c.mode = $urandom_range(MODE_SPARE_LO, MODE_SPARE_HI);
    end
  endtask

  task automatic run_random(int n);
    cmd_t c;
    repeat (n) begin
      make_cmd(c);
      send(c, 1'b0, '0, 1'b0, 1'b0);
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic apb_write(reg_sel_t idx, logic [APB_DATA_W-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MIN_TENTHS:     cfg.lo       = v[FREQ_W-1:0];
      REG_MAX_TENTHS:     cfg.hi       = v[FREQ_W-1:0];
      REG_IF_OFFSET:      cfg.offset   = v[OFFSET_W-1:0];
      REG_VHF_HIGH_START: cfg.vhf_high = v[FREQ_W-1:0];
      REG_UHF_START:      cfg.uhf      = v[FREQ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Retune the limits once the block has drained.
  task automatic set_tuning(tuning_cfg_t t);
    cmd_if.valid = 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_write(REG_MIN_TENTHS, 32'(t.lo));
    apb_write(REG_MAX_TENTHS, 32'(t.hi));
    apb_write(REG_IF_OFFSET, 32'(t.offset));
    apb_write(REG_VHF_HIGH_START, 32'(t.vhf_high));
    apb_write(REG_UHF_START, 32'(t.uhf));
    burst_left = 0;
  endtask

  initial begin
    tuning_cfg_t t;
    cmd_t        c;

    cmd_if.valid        = 1'b0;
    cmd_if.mode         = MODE_ENCODER;
    cmd_if.encoder_pins = '0;
    cmd_if.entry_mhz    = '0;
    cmd_if.entry_tenth  = '0;
    cmd_if.slot_index   = '0;
    stat_if.ready       = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;

    // Predicted state after reset.
    cfg            = '{MIN_TENTHS_RST, MAX_TENTHS_RST, IF_OFFSET_RST, VHF_HIGH_START_RST,
                       UHF_START_RST};
    freq_st        = FREQ_RST;
    pins_st        = '0;
    boost_st       = 1'b0;
    slot_ok[0]     = 1'b0;
    slot_ok[1]     = 1'b0;
    slot_tenths[0] = '0;
    slot_tenths[1] = '0;

    // Directed words under reset limits; pinned rows check frequency and flags by hand.
    dir_rows = '{
      // Encoder: idle, step below the floor, three steps up, a skipped state.
      '{'{MODE_ENCODER, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd450, 1'b0, 1'b0},
      '{'{MODE_ENCODER, 2'd2, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd450, 1'b0, 1'b1},
      '{'{MODE_ENCODER, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd451, 1'b0, 1'b0},
      '{'{MODE_ENCODER, 2'd1, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd452, 1'b0, 1'b0},
      '{'{MODE_ENCODER, 2'd3, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd453, 1'b0, 1'b0},
      '{'{MODE_ENCODER, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd453, 1'b0, 1'b0},
      // Direct entry: both edges of the accepted range, field extremes, tenth too big.
      '{'{MODE_ENTRY, 2'd0, 10'd44, 4'd0, 1'b0}, 1'b1, 14'd453, 1'b1, 1'b0},
      '{'{MODE_ENTRY, 2'd3, 10'd871, 4'd0, 1'b0}, 1'b1, 14'd453, 1'b1, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd45, 4'd0, 1'b0}, 1'b1, 14'd450, 1'b0, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd870, 4'd9, 1'b0}, 1'b1, 14'd8700, 1'b0, 1'b1},
      '{'{MODE_ENTRY, 2'd0, 10'd1023, 4'd15, 1'b1}, 1'b1, 14'd8700, 1'b1, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd8700, 1'b1, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd100, 4'd15, 1'b0}, 1'b1, 14'd1009, 1'b0, 1'b0},
      // Buttons and memory slots: store, move away, recall and clear.
      '{'{MODE_BOOSTER, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b0, 14'd0, 1'b0, 1'b0},
      '{'{MODE_STANDBY, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b0, 14'd0, 1'b0, 1'b0},
      '{'{MODE_SLOT, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b0, 14'd0, 1'b0, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd500, 4'd0, 1'b0}, 1'b1, 14'd5000, 1'b0, 1'b0},
      '{'{MODE_SLOT, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd1009, 1'b0, 1'b0},
      '{'{MODE_SLOT, 2'd0, 10'd0, 4'd0, 1'b1}, 1'b0, 14'd0, 1'b0, 1'b0},
      '{'{MODE_ENTRY, 2'd0, 10'd137, 4'd5, 1'b0}, 1'b1, 14'd1375, 1'b0, 1'b0},
      '{'{MODE_SLOT, 2'd0, 10'd0, 4'd0, 1'b1}, 1'b1, 14'd1009, 1'b0, 1'b0},
      // Unused command codes leave the frequency alone.
      '{'{MODE_SPARE_LO, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd1009, 1'b0, 1'b0},
      '{'{MODE_SPARE_HI, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd1009, 1'b0, 1'b0},
      '{'{MODE_BOOSTER, 2'd0, 10'd0, 4'd0, 1'b0}, 1'b0, 14'd0, 1'b0, 1'b0},
      '{'{MODE_ENCODER, 2'd2, 10'd0, 4'd0, 1'b0}, 1'b1, 14'd1008, 1'b0, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      send(dir_rows[i].cmd, dir_rows[i].pinned, dir_rows[i].freq, dir_rows[i].err,
           dir_rows[i].hit);
    end
    run_random(300);

    // Both limits at zero: every step clamps at the bottom.
    t = '{14'd0, 14'd0, 12'd0, 14'd0, 14'd0};
    set_tuning(t);
    run_random(20);

    // Widest window, largest offset, band thresholds at the top.
    t = '{14'd0, 14'd16383, 12'd4095, 14'd16383, 14'd16383};
    set_tuning(t);
    run_random(200);

    // Pinned at the top of the field, band thresholds at zero.
    t = '{14'd16383, 14'd16383, 12'd4095, 14'd0, 14'd0};
    set_tuning(t);
    run_random(20);

    // Crossed limits: the lower one wins.
    t = '{14'd5000, 14'd3000, 12'd100, 14'd2000, 14'd6000};
    set_tuning(t);
    run_random(60);

    repeat (3) begin
      t.lo       = $urandom_range(0, 4000);
      t.hi       = $urandom_range(t.lo, 16383);
      t.offset   = $urandom_range(0, 4095);
      t.vhf_high = $urandom_range(0, 9000);
      t.uhf      = $urandom_range(t.vhf_high, 16383);
      set_tuning(t);
      run_random(100);
    end

    t = '{MIN_TENTHS_RST, MAX_TENTHS_RST, IF_OFFSET_RST, VHF_HIGH_START_RST, UHF_START_RST};
    set_tuning(t);
    run_random(300);

    // Drain and report.
    cmd_if.valid = 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
